@@ src/sha256_stream_hasher_defines.svh @@
// Assertion macros for the SHA-256 stream hasher checker.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define SHA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sha256sh_pkg.sv @@
// Shared types, constants and round-constant table for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package sha256sh_pkg;

    // Source of the byte shifted into the block buffer.
    typedef logic [1:0] byte_sel_t;
    localparam byte_sel_t SEL_INPUT = 2'd0;
    localparam byte_sel_t SEL_PAD80 = 2'd1;
    localparam byte_sel_t SEL_ZERO  = 2'd2;
    localparam byte_sel_t SEL_LEN   = 2'd3;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUND_W  = 6;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned COUNT_W  = 61;  // byte count; bit length is count * 8 mod 2^64

    localparam logic [FILL_W-1:0]  FILL_LAST    = 6'd63;
    localparam logic [FILL_W-1:0]  FILL_PRE_LEN = 6'd55;
    localparam logic [ROUND_W-1:0] ROUND_LAST   = 6'd63;

    localparam logic [8*WORD_W-1:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic                shift_en;
        byte_sel_t           byte_sel;
        logic                count_inc;
        logic                load_len;
        logic                round_init;
        logic                round_en;
        logic [ROUND_W-1:0]  round_idx;
        logic                h_add;
        logic                finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] sha_k(input logic [ROUND_W-1:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ src/sha256_stream_hasher.sv @@
// Top level of the byte-stream SHA-256 hasher: controller plus datapath.
// Throughput: one byte word per cycle while a block fills; no bytes are taken while a 64-byte block
//   is compressed (64 rounds of the single round unit plus one chaining add).
// End of message: padding (0x80, zeros, 64-bit length) follows the final word and needs a second block
//   if fill > 55 (fill = bytes in the open block); word 0 waits while a previous digest drains.
// Reset: synchronous, active-low aresetn; chaining words return to the initial hash values.
`timescale 1ns / 1ps

module sha256_stream_hasher
    import sha256sh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Message byte channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message

    // Digest word channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller accepts bytes only while no block is compressing and
    // no padding is in flight; the datapath output stage drains on its own.
    sha256sh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Block buffer doubles as the rolling 16-word message schedule.
    sha256sh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/sha256sh_ctrl.sv @@
// Controller FSM: byte intake, padding sequence, round count and digest hand-off.
`timescale 1ns / 1ps

module sha256sh_ctrl
    import sha256sh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    input  logic       s_tlast,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PAD80   = 3'd1;
    localparam logic [2:0] ST_PADZERO = 3'd2;
    localparam logic [2:0] ST_PADLEN  = 3'd3;
    localparam logic [2:0] ST_ROUND   = 3'd4;
    localparam logic [2:0] ST_ADD     = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         ret_reg, ret_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        cmd.round_idx = rnd_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.shift_en  = 1'b1;
                        cmd.byte_sel  = SEL_INPUT;
                        cmd.count_inc = 1'b1;
                        fill_next     = fill_reg + 1'b1;
                        if (fill_reg == FILL_LAST) begin
                            cmd.round_init = 1'b1;
                            rnd_next       = '0;
                            state_next     = ST_ROUND;
                            ret_next       = s_tlast ? ST_PAD80 : ST_IDLE;
                        end else if (s_tlast) begin
                            state_next = ST_PAD80;
                        end
                    end else if (s_tlast) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_PAD80;
                cmd.load_len = 1'b1;
                fill_next    = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST) begin
                    cmd.round_init = 1'b1;
                    rnd_next       = '0;
                    state_next     = ST_ROUND;
                    ret_next       = ST_PADZERO;
                end else if (fill_reg == FILL_PRE_LEN) begin
                    state_next = ST_PADLEN;
                end else begin
                    state_next = ST_PADZERO;
                end
            end
            ST_PADZERO: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_ZERO;
                fill_next    = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST) begin
                    cmd.round_init = 1'b1;
                    rnd_next       = '0;
                    state_next     = ST_ROUND;
                    ret_next       = ST_PADZERO;
                end else if (fill_reg == FILL_PRE_LEN) begin
                    state_next = ST_PADLEN;
                end
            end
            ST_PADLEN: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_LEN;
                fill_next    = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST) begin
                    cmd.round_init = 1'b1;
                    rnd_next       = '0;
                    state_next     = ST_ROUND;
                    ret_next       = ST_FINISH;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.h_add  = 1'b1;
                state_next = ret_reg;
            end
            ST_FINISH: begin
                // hold the new digest until the previous one has drained
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

@@ src/sha256sh_datapath.sv @@
// Datapath: block shift buffer / schedule window, round logic, chaining words, output stage.
`timescale 1ns / 1ps

module sha256sh_datapath
    import sha256sh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    localparam int unsigned BLK_W = 16 * WORD_W;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Block bytes shift in at the bottom; the top word is W[t] during rounds.
    logic [BLK_W-1:0]    blk_reg;
    logic [WORD_W-1:0]   v_reg [8];
    logic [WORD_W-1:0]   h_reg [8];
    logic [COUNT_W-1:0]  count_reg;
    logic [63:0]         len_reg;
    logic [8*WORD_W-1:0] out_reg;
    logic [2:0]          out_idx_reg;
    logic                out_valid_reg;

    logic [7:0]        byte_in;
    logic [WORD_W-1:0] w0, w1, w9, w14;
    logic [WORD_W-1:0] sched_new, t1, t2, ch, maj;
    logic              out_take;

    always_comb begin
        case (cmd.byte_sel)
            SEL_INPUT: byte_in = s_tdata;
            SEL_PAD80: byte_in = 8'h80;
            SEL_ZERO:  byte_in = 8'h00;
            SEL_LEN:   byte_in = len_reg[63:56];
            default:   byte_in = 8'h00;
        endcase
    end

    assign w0  = blk_reg[BLK_W-1 -: WORD_W];
    assign w1  = blk_reg[BLK_W-1*WORD_W-1 -: WORD_W];
    assign w9  = blk_reg[BLK_W-9*WORD_W-1 -: WORD_W];
    assign w14 = blk_reg[BLK_W-14*WORD_W-1 -: WORD_W];

    assign sched_new = ssig1(w14) + w9 + ssig0(w1) + w0;
    assign ch        = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj       = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1        = v_reg[7] + bsig1(v_reg[4]) + ch + sha_k(cmd.round_idx) + w0;
    assign t2        = bsig0(v_reg[0]) + maj;

    assign out_take = out_valid_reg && m_tready;

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            blk_reg <= {blk_reg[BLK_W-9:0], byte_in};
        end else if (cmd.round_en) begin
            blk_reg <= {blk_reg[BLK_W-WORD_W-1:0], sched_new};
        end

        if (cmd.round_init) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_en) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end

        if (cmd.load_len) begin
            len_reg <= {count_reg, 3'b000};
        end else if (cmd.shift_en && (cmd.byte_sel == SEL_LEN)) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end

        if (cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
                out_reg[8*WORD_W-1-WORD_W*i -: WORD_W] <= h_reg[i];
            end
        end else if (out_take) begin
            out_reg <= {out_reg[7*WORD_W-1:0], {WORD_W{1'b0}}};
        end
    end

    // Chaining words, byte count and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= SHA_IV[8*WORD_W-1-WORD_W*i -: WORD_W];
            end
            count_reg     <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= SHA_IV[8*WORD_W-1-WORD_W*i -: WORD_W];
                end
                count_reg <= '0;
            end else begin
                if (cmd.h_add) begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                if (cmd.count_inc) begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end else if (out_take) begin
                out_idx_reg <= out_idx_reg + 1'b1;
                if (out_idx_reg == 3'd7) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign status.out_busy = out_valid_reg;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {5'b00000, out_idx_reg, out_reg[8*WORD_W-1 -: WORD_W]};
    assign m_tlast         = (out_idx_reg == 3'd7);

endmodule

@@ src/sha256sh_checker.sv @@
// Port-level checker for the digest channel, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

module sha256sh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    `SHA_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "digest word changed under stall")
    `SHA_ASSERT_SAME(a_last_idx, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7), "tlast not on word seven")
    `SHA_ASSERT_NEXT(a_idx_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[34:32] == ($past(m_tdata[34:32]) + 3'd1)), "digest word index skipped")
    `SHA_ASSERT_SAME(a_first_idx, $rose(m_tvalid), m_tdata[34:32] == 3'd0, "digest does not start at word zero")
    `SHA_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[39:35] == 5'd0, "tdata fill bits not zero")

endmodule

bind sha256_stream_hasher sha256sh_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
